[rtl/smvm_pkg.sv]
package smvm_pkg;

    // field widths
    localparam int IDX_W   = 10;
    localparam int VALUE_W = 32;
    localparam int ACC_W   = 48;
    localparam int PROD_W  = 64;
    localparam int FRAC_W  = 5;
    localparam int OP_W    = 2;

    // shifted product clamp width, wide enough that clamping never changes a saturated sum
    localparam int ADD_W   = ACC_W + 2;
    localparam int SUM_W   = ADD_W + 1;

    // stream packing
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 64;
    localparam int M_PAD_W   = M_TDATA_W - IDX_W - ACC_W;
    localparam int S_VEC_LO  = 0;
    localparam int S_ACC_LO  = IDX_W;
    localparam int S_VAL_LO  = 2 * IDX_W;

    // defaults
    localparam int VEC_DEPTH_DEFAULT = 1024;
    localparam int ACC_DEPTH_DEFAULT = 1024;
    localparam logic [FRAC_W-1:0] FRAC_RESET = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_PRESET = 2'd1,
        OP_APPLY  = 2'd2,
        OP_READ   = 2'd3
    } opcode_t;

endpackage

[rtl/sparse_matrix_vector_multiply.sv]
// Sparse matrix times vector engine. Each input transfer carries one operation in s_tuser:
// load a vector element, preset an accumulator, apply one nonzero entry
// (acc[acc_index] += (value * vec[vec_index]) >>> fraction_bits, saturated to 48 bits), or
// read an accumulator, which is the only operation that gives an output transfer. Swap the
// two indices in the entry stream to form the transposed product. The block takes one
// item per cycle while s_tready is high, also back-to-back entries on one accumulator; the
// vector and accumulator memories are each read and written once per cycle and a three-deep
// write history forwards accumulator updates still in flight. A read result passes stages 1
// to 3 and the output register to m_tdata. An output register and a skid entry let input
// continue while one result waits; s_tready drops only when two results are waiting. The
// user must write fraction_bits through cfg_wr_en only while idle; the block does not check.
module sparse_matrix_vector_multiply #(
    parameter int VEC_DEPTH = smvm_pkg::VEC_DEPTH_DEFAULT,
    parameter int ACC_DEPTH = smvm_pkg::ACC_DEPTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             cfg_wr_en,
    input  logic [smvm_pkg::FRAC_W-1:0]      cfg_wr_data,   // fraction_bits
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [smvm_pkg::S_TDATA_W-1:0]   s_tdata,   // vec_index, acc_index, item_value
    input  logic [smvm_pkg::OP_W-1:0]        s_tuser,   // opcode
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [smvm_pkg::M_TDATA_W-1:0]   m_tdata    // result_index, result_value
);

    localparam int VEC_AW  = $clog2(VEC_DEPTH);
    localparam int ACC_AW  = $clog2(ACC_DEPTH);
    localparam int IDX_W   = smvm_pkg::IDX_W;
    localparam int VALUE_W = smvm_pkg::VALUE_W;
    localparam int ACC_W   = smvm_pkg::ACC_W;
    localparam int PROD_W  = smvm_pkg::PROD_W;
    localparam int ADD_W   = smvm_pkg::ADD_W;
    localparam int SUM_W   = smvm_pkg::SUM_W;

    localparam logic signed [SUM_W-1:0] ACC_MAX = SUM_W'((64'sd1 <<< (ACC_W - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] ACC_MIN = SUM_W'(-(64'sd1 <<< (ACC_W - 1)));
    localparam logic signed [ADD_W-1:0] ADD_MAX = ADD_W'((64'sd1 <<< (ADD_W - 1)) - 64'sd1);
    localparam logic signed [ADD_W-1:0] ADD_MIN = ADD_W'(-(64'sd1 <<< (ADD_W - 1)));

    // input field unpacking
    smvm_pkg::opcode_t          in_op;
    logic [IDX_W-1:0]           in_vec_idx;
    logic [IDX_W-1:0]           in_acc_idx;
    logic signed [VALUE_W-1:0]  in_value;
    logic                       in_vok;
    logic                       in_aok;
    logic [VEC_AW-1:0]          in_vec_addr;
    logic [ACC_AW-1:0]          in_acc_addr;
    logic                       advance;
    logic                       in_fire;

    assign in_op      = smvm_pkg::opcode_t'(s_tuser);
    assign in_vec_idx = s_tdata[smvm_pkg::S_VEC_LO +: IDX_W];
    assign in_acc_idx = s_tdata[smvm_pkg::S_ACC_LO +: IDX_W];
    assign in_value   = s_tdata[smvm_pkg::S_VAL_LO +: VALUE_W];
    assign in_vok     = 32'(in_vec_idx) < 32'(VEC_DEPTH);
    assign in_aok     = 32'(in_acc_idx) < 32'(ACC_DEPTH);
    assign in_vec_addr = VEC_AW'(in_vec_idx);
    assign in_acc_addr = ACC_AW'(in_acc_idx);

    // configuration register
    logic [smvm_pkg::FRAC_W-1:0] frac_bits_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frac_bits_reg <= smvm_pkg::FRAC_RESET;
        end else if (cfg_wr_en) begin
            frac_bits_reg <= cfg_wr_data;
        end
    end

    // pipeline moves whenever the skid entry is free
    logic skid_valid_reg;

    assign advance  = !skid_valid_reg;
    assign s_tready = advance;
    assign in_fire  = s_tvalid && advance;

    // memories
    logic [VALUE_W-1:0] vec_rd_data;
    logic [ACC_W-1:0]   acc_rd_data;
    logic               acc_wr_en;
    logic [ACC_AW-1:0]  acc_wr_addr;
    logic [ACC_W-1:0]   acc_wr_data;

    smvm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (VEC_DEPTH)
    ) u_vec_ram (
        .aclk    (aclk),
        .wr_en   (in_fire && in_op == smvm_pkg::OP_LOAD && in_vok),
        .wr_addr (in_vec_addr),
        .wr_data (in_value),
        .rd_en   (advance),
        .rd_addr (in_vec_addr),
        .rd_data (vec_rd_data)
    );

    smvm_ram #(
        .WIDTH (ACC_W),
        .DEPTH (ACC_DEPTH)
    ) u_acc_ram (
        .aclk    (aclk),
        .wr_en   (acc_wr_en),
        .wr_addr (acc_wr_addr),
        .wr_data (acc_wr_data),
        .rd_en   (advance),
        .rd_addr (in_acc_addr),
        .rd_data (acc_rd_data)
    );

    // stage registers
    logic                       s1_valid_reg, s2_valid_reg, s3_valid_reg;
    smvm_pkg::opcode_t          s1_op_reg, s2_op_reg, s3_op_reg;
    logic                       s1_aok_reg, s2_aok_reg, s3_aok_reg;
    logic                       s1_vok_reg;
    logic [IDX_W-1:0]           s1_idx_reg, s2_idx_reg, s3_idx_reg;
    logic signed [VALUE_W-1:0]  s1_value_reg;
    logic signed [PROD_W-1:0]   s2_prod_reg;
    logic [ACC_W-1:0]           s2_acc_reg, s3_acc_reg;
    logic signed [ADD_W-1:0]    s3_addend_reg;

    // write history for forwarding, newest first
    logic                       w1_valid_reg, w2_valid_reg, w3_valid_reg;
    logic [ACC_AW-1:0]          w1_addr_reg, w2_addr_reg, w3_addr_reg;
    logic [ACC_W-1:0]           w1_data_reg, w2_data_reg, w3_data_reg;

    // stage 1: multiply by the vector element, or pass the value for other operations
    logic signed [VALUE_W-1:0]  s1_vec;
    logic signed [PROD_W-1:0]   s2_prod_next;

    always_comb begin
        s1_vec = s1_vok_reg ? $signed(vec_rd_data) : '0;
        if (s1_op_reg == smvm_pkg::OP_APPLY) begin
            s2_prod_next = PROD_W'(s1_value_reg) * PROD_W'(s1_vec);
        end else begin
            s2_prod_next = PROD_W'(s1_value_reg);
        end
    end

    // stage 2: floor shift and clamp of the product; other operations pass unshifted
    logic signed [PROD_W-1:0]   s2_shifted;
    logic signed [ADD_W-1:0]    s3_addend_next;

    always_comb begin
        s2_shifted = s2_prod_reg >>> frac_bits_reg;
        if (s2_op_reg != smvm_pkg::OP_APPLY) begin
            s3_addend_next = ADD_W'(s2_prod_reg);
        end else if (s2_shifted > PROD_W'(ADD_MAX)) begin
            s3_addend_next = ADD_MAX;
        end else if (s2_shifted < PROD_W'(ADD_MIN)) begin
            s3_addend_next = ADD_MIN;
        end else begin
            s3_addend_next = ADD_W'(s2_shifted);
        end
    end

    // stage 3: forward, accumulate, saturate and write back
    logic [ACC_AW-1:0]          s3_addr;
    logic [ACC_W-1:0]           s3_operand;
    logic signed [SUM_W-1:0]    s3_sum;
    logic [ACC_W-1:0]           s3_sat;
    logic                       s3_read_fire;

    always_comb begin
        s3_addr = ACC_AW'(s3_idx_reg);
        if (w1_valid_reg && w1_addr_reg == s3_addr) begin
            s3_operand = w1_data_reg;
        end else if (w2_valid_reg && w2_addr_reg == s3_addr) begin
            s3_operand = w2_data_reg;
        end else if (w3_valid_reg && w3_addr_reg == s3_addr) begin
            s3_operand = w3_data_reg;
        end else begin
            s3_operand = s3_acc_reg;
        end
        s3_sum = SUM_W'($signed(s3_operand)) + SUM_W'(s3_addend_reg);
        if (s3_sum > ACC_MAX) begin
            s3_sat = ACC_MAX[ACC_W-1:0];
        end else if (s3_sum < ACC_MIN) begin
            s3_sat = ACC_MIN[ACC_W-1:0];
        end else begin
            s3_sat = s3_sum[ACC_W-1:0];
        end
        acc_wr_en   = advance && s3_valid_reg && s3_aok_reg &&
                      (s3_op_reg == smvm_pkg::OP_PRESET || s3_op_reg == smvm_pkg::OP_APPLY);
        acc_wr_addr = s3_addr;
        acc_wr_data = (s3_op_reg == smvm_pkg::OP_PRESET) ? ACC_W'(s3_addend_reg) : s3_sat;
        s3_read_fire = advance && s3_valid_reg && s3_op_reg == smvm_pkg::OP_READ;
    end

    // pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            w1_valid_reg <= 1'b0;
            w2_valid_reg <= 1'b0;
            w3_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            w1_valid_reg <= acc_wr_en;
            w2_valid_reg <= w1_valid_reg;
            w3_valid_reg <= w2_valid_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_op_reg     <= in_op;
            s1_aok_reg    <= in_aok;
            s1_vok_reg    <= in_vok;
            s1_idx_reg    <= in_acc_idx;
            s1_value_reg  <= in_value;

            s2_op_reg     <= s1_op_reg;
            s2_aok_reg    <= s1_aok_reg;
            s2_idx_reg    <= s1_idx_reg;
            s2_prod_reg   <= s2_prod_next;
            s2_acc_reg    <= acc_rd_data;

            s3_op_reg     <= s2_op_reg;
            s3_aok_reg    <= s2_aok_reg;
            s3_idx_reg    <= s2_idx_reg;
            s3_addend_reg <= s3_addend_next;
            s3_acc_reg    <= s2_acc_reg;

            w1_addr_reg   <= acc_wr_addr;
            w1_data_reg   <= acc_wr_data;
            w2_addr_reg   <= w1_addr_reg;
            w2_data_reg   <= w1_data_reg;
            w3_addr_reg   <= w2_addr_reg;
            w3_data_reg   <= w2_data_reg;
        end
    end

    // output register and skid entry
    logic               out_valid_reg;
    logic [IDX_W-1:0]   out_idx_reg, skid_idx_reg;
    logic [ACC_W-1:0]   out_value_reg, skid_value_reg;
    logic [ACC_W-1:0]   rd_value;

    assign rd_value = s3_aok_reg ? s3_operand : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                out_idx_reg    <= skid_idx_reg;
                out_value_reg  <= skid_value_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (s3_read_fire) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_reg <= 1'b1;
                out_idx_reg   <= s3_idx_reg;
                out_value_reg <= rd_value;
            end else begin
                skid_valid_reg <= 1'b1;
                skid_idx_reg   <= s3_idx_reg;
                skid_value_reg <= rd_value;
            end
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{smvm_pkg::M_PAD_W{1'b0}}, out_value_reg, out_idx_reg};

endmodule

[rtl/smvm_ram.sv]
module smvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // single write port, registered read that returns the old word on a collision
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[dv/testbench.sv]
module testbench;

    localparam int     IDX_W        = smvm_pkg::IDX_W;
    localparam int     VALUE_W      = smvm_pkg::VALUE_W;
    localparam int     ACC_W        = smvm_pkg::ACC_W;
    localparam int     FRAC_W       = smvm_pkg::FRAC_W;
    localparam int     VEC_DEPTH    = smvm_pkg::VEC_DEPTH_DEFAULT;
    localparam int     ACC_DEPTH    = smvm_pkg::ACC_DEPTH_DEFAULT;
    localparam int     CYCLE_LIMIT  = 500000;
    localparam int     PHASE_ITEMS  = 200;
    localparam int     DRAIN_CYCLES = 8;
    localparam longint ACC_MAX      = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_MIN      = -ACC_MAX - 1;

    typedef struct {
        smvm_pkg::opcode_t         op;
        logic [IDX_W-1:0]          vec_idx;
        logic [IDX_W-1:0]          acc_idx;
        logic signed [VALUE_W-1:0] value;
    } smvm_item_t;

    typedef struct {
        logic [IDX_W-1:0]        idx;
        logic signed [ACC_W-1:0] value;
    } acc_read_t;

    logic                           aclk        = 1'b0;
    logic                           aresetn     = 1'b0;
    logic                           cfg_wr_en   = 1'b0;
    logic [FRAC_W-1:0]              cfg_wr_data = '0;
    logic                           s_tvalid    = 1'b0;
    logic                           s_tready;
    logic [smvm_pkg::S_TDATA_W-1:0] s_tdata     = '0;
    logic [smvm_pkg::OP_W-1:0]      s_tuser     = '0;
    logic                           m_tvalid;
    logic                           m_tready    = 1'b0;
    logic [smvm_pkg::M_TDATA_W-1:0] m_tdata;

    // items waiting to be driven, and accumulator reads still owed by the block
    smvm_item_t ops_to_send[$];
    acc_read_t  reads_due[$];

    // shadow copy of the block state, advanced on every accepted input transfer
    logic signed [VALUE_W-1:0] shadow_vec[VEC_DEPTH];
    logic signed [ACC_W-1:0]   shadow_acc[ACC_DEPTH];
    logic [FRAC_W-1:0]         shadow_frac = smvm_pkg::FRAC_RESET;

    // entries written so far, as seen by the stimulus side
    bit vec_loaded[VEC_DEPTH];
    bit acc_loaded[ACC_DEPTH];
    int vec_known[$];
    int acc_known[$];
    int items_queued = 0;

    int  mismatches  = 0;
    int  cycle_count = 0;
    bit  in_fire     = 1'b0;
    int  burst_left  = 0;
    int  gap_left    = 0;
    int  stall_count = 0;
    int  stall_mode  = 0;
    logic [31:0] stall_bits = '1;

    smvm_item_t              next_op;
    smvm_item_t              seen_op;
    acc_read_t               owed;
    logic [IDX_W-1:0]        got_idx;
    logic signed [ACC_W-1:0] got_value;

    sparse_matrix_vector_multiply i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
        mismatches++;
    endtask

    // advance the shadow state by one operation, noting any read it owes
    task automatic shadow_step(input smvm_item_t it);
        longint    prod;
        longint    sum;
        acc_read_t rd;
        case (it.op)
            smvm_pkg::OP_LOAD: begin
                shadow_vec[it.vec_idx] = it.value;
            end
            smvm_pkg::OP_PRESET: begin
                shadow_acc[it.acc_idx] = ACC_W'(longint'(it.value));
            end
            smvm_pkg::OP_APPLY: begin
                prod = longint'(it.value) * longint'(shadow_vec[it.vec_idx]);
                sum  = longint'(shadow_acc[it.acc_idx]) + (prod >>> shadow_frac);
                if (sum > ACC_MAX)
                    sum = ACC_MAX;
                else if (sum < ACC_MIN)
                    sum = ACC_MIN;
                shadow_acc[it.acc_idx] = ACC_W'(sum);
            end
            default: begin
                rd.idx   = it.acc_idx;
                rd.value = shadow_acc[it.acc_idx];
                reads_due.push_back(rd);
            end
        endcase
    endtask

    // monitor: check result transfers, then predict from input transfers
    always @(posedge aclk) begin
        in_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got_idx   = m_tdata[IDX_W-1:0];
                got_value = m_tdata[IDX_W +: ACC_W];
                if (reads_due.size() == 0) begin
                    flag_mismatch("unexpected result, index", longint'(got_idx), -1);
                end else begin
                    owed = reads_due.pop_front();
                    if (got_idx !== owed.idx)
                        flag_mismatch("result_index", longint'(got_idx), longint'(owed.idx));
                    if (got_value !== owed.value)
                        flag_mismatch("result_value", longint'(got_value), longint'(owed.value));
                end
            end
            if (s_tvalid && s_tready) begin
                seen_op.op      = smvm_pkg::opcode_t'(s_tuser);
                seen_op.vec_idx = s_tdata[smvm_pkg::S_VEC_LO +: IDX_W];
                seen_op.acc_idx = s_tdata[smvm_pkg::S_ACC_LO +: IDX_W];
                seen_op.value   = s_tdata[smvm_pkg::S_VAL_LO +: VALUE_W];
                shadow_step(seen_op);
            end
        end
    end

    // driver: bursts of transfers with random gaps between them
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (gap_left > 0 || ops_to_send.size() == 0) begin
                if (gap_left > 0)
                    gap_left--;
                s_tvalid <= 1'b0;
            end else begin
                next_op = ops_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_op.op;
                s_tdata  <= {{(smvm_pkg::S_TDATA_W - smvm_pkg::S_VAL_LO - VALUE_W){1'b0}},
                             next_op.value, next_op.acc_idx, next_op.vec_idx};
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // receiver: one of four stall modes, with mode and bit pattern redrawn at random
    always @(negedge aclk) begin
        stall_count++;
        if (stall_count % 64 == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_bits = $urandom;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= stall_bits[stall_count % 32];
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // operand value: extremes, zero, small signed or anything
    function automatic logic signed [VALUE_W-1:0] rand_value();
        logic signed [VALUE_W-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 7))
            0:       v = 32'sh7FFF_FFFF;
            1:       v = 32'sh8000_0000;
            2:       v = 32'sd0;
            3, 4:    v = v >>> 14;
            default: v = v;
        endcase
        return v;
    endfunction

    task automatic send(input smvm_pkg::opcode_t op, input int vi, input int ai,
                        input logic signed [VALUE_W-1:0] value);
        smvm_item_t it;
        it.op      = op;
        it.vec_idx = IDX_W'(vi);
        it.acc_idx = IDX_W'(ai);
        it.value   = value;
        ops_to_send.push_back(it);
        items_queued++;
        if (op == smvm_pkg::OP_LOAD && !vec_loaded[vi]) begin
            vec_loaded[vi] = 1'b1;
            vec_known.push_back(vi);
        end
        if (op == smvm_pkg::OP_PRESET && !acc_loaded[ai]) begin
            acc_loaded[ai] = 1'b1;
            acc_known.push_back(ai);
        end
    endtask

    function automatic int any_idx();
        return $urandom_range(0, VEC_DEPTH - 1);
    endfunction

    // one product pass: load a vector, preset rows, stream entries, read rows back;
    // the transposed product is the same stream with the two indices swapped
    task automatic queue_product();
        int n_cols;
        int n_rows;
        int cols[$];
        int rows[$];
        n_cols = $urandom_range(1, 6);
        n_rows = $urandom_range(1, 6);
        for (int c = 0; c < n_cols; c++) begin
            cols.push_back(any_idx());
            send(smvm_pkg::OP_LOAD, cols[c], any_idx(), rand_value());
        end
        for (int r = 0; r < n_rows; r++) begin
            rows.push_back(any_idx());
            // keep the prior contents now and then, to add onto earlier results
            if (!(acc_loaded[rows[r]] && $urandom_range(0, 2) == 0))
                send(smvm_pkg::OP_PRESET, any_idx(), rows[r],
                     ($urandom_range(0, 1) == 0) ? 32'sd0 : rand_value());
        end
        for (int r = 0; r < n_rows; r++)
            for (int c = 0; c < n_cols; c++)
                if ($urandom_range(0, 9) < 5)
                    send(smvm_pkg::OP_APPLY, cols[c], rows[r], rand_value());
        for (int r = 0; r < n_rows; r++)
            send(smvm_pkg::OP_READ, any_idx(), rows[r], rand_value());
    endtask

    // loose operations on entries already written, or writes of new ones
    task automatic queue_noise();
        int n;
        int pick;
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 3);
            if (pick == 2 && (vec_known.size() == 0 || acc_known.size() == 0))
                pick = 0;
            if (pick == 3 && acc_known.size() == 0)
                pick = 1;
            case (pick)
                0: send(smvm_pkg::OP_LOAD, any_idx(), any_idx(), rand_value());
                1: send(smvm_pkg::OP_PRESET, any_idx(), any_idx(), rand_value());
                2: send(smvm_pkg::OP_APPLY, vec_known[$urandom_range(0, vec_known.size() - 1)],
                        acc_known[$urandom_range(0, acc_known.size() - 1)], rand_value());
                default: send(smvm_pkg::OP_READ, any_idx(),
                              acc_known[$urandom_range(0, acc_known.size() - 1)], rand_value());
            endcase
        end
    endtask

    // wait until everything is sent and answered, then let the pipeline settle
    task automatic wait_idle();
        while (ops_to_send.size() != 0 || s_tvalid || reads_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_frac(input logic [FRAC_W-1:0] f);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= f;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        shadow_frac = f;
    endtask

    // stimulus
    initial begin
        logic [FRAC_W-1:0] phase_frac[7];
        int                phase_start;
        phase_frac = '{5'd0, 5'd31, 5'd8, 5'd16, 5'd1, 5'($urandom), 5'($urandom)};

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extreme operands, saturation both ways, back-to-back updates
        send(smvm_pkg::OP_LOAD,   0,    3,    32'sh7FFF_FFFF);
        send(smvm_pkg::OP_LOAD,   1023, 1023, 32'sh8000_0000);
        send(smvm_pkg::OP_LOAD,   5,    0,    32'sh0001_0000);
        send(smvm_pkg::OP_PRESET, 0,    0,    32'sd0);
        send(smvm_pkg::OP_PRESET, 1023, 1023, 32'sh7FFF_FFFF);
        send(smvm_pkg::OP_PRESET, 0,    7,    32'sh8000_0000);
        repeat (3) send(smvm_pkg::OP_APPLY, 0, 0, 32'sh7FFF_FFFF);
        send(smvm_pkg::OP_READ,   0,    0,    32'sd0);
        repeat (3) send(smvm_pkg::OP_APPLY, 1023, 7, 32'sh7FFF_FFFF);
        send(smvm_pkg::OP_READ,   1023, 7,    32'sh7FFF_FFFF);
        send(smvm_pkg::OP_APPLY,  1023, 1023, 32'sh8000_0000);
        send(smvm_pkg::OP_READ,   0,    1023, 32'sd0);
        send(smvm_pkg::OP_APPLY,  5,    0,    32'sh8000_0000);
        send(smvm_pkg::OP_APPLY,  5,    0,    -32'sd1);
        send(smvm_pkg::OP_READ,   0,    0,    32'sd0);
        send(smvm_pkg::OP_READ,   1023, 0,    32'sh8000_0000);

        // random phases, each under its own fraction width
        foreach (phase_frac[p]) begin
            wait_idle();
            write_frac(phase_frac[p]);
            phase_start = items_queued;
            while (items_queued - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 7)
                    queue_product();
                else
                    queue_noise();
            end
        end

        wait_idle();
        repeat (16) @(posedge aclk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
